/* hw/rtl/bpg_pkg.sv */
package bpg_pkg;

    localparam int TIMER_WIDTH = 16;
    localparam int CFG_WIDTH   = 16;
    localparam int EDGE_WIDTH  = 8;

    // input item kinds
    localparam logic [1:0] MODE_TICK    = 2'd0;
    localparam logic [1:0] MODE_TRIGGER = 2'd1;
    localparam logic [1:0] MODE_STOP    = 2'd2;

    // pattern codes
    localparam logic [2:0] PAT_NONE      = 3'd0;
    localparam logic [2:0] PAT_ARRIVAL   = 3'd1;
    localparam logic [2:0] PAT_KEY       = 3'd2;
    localparam logic [2:0] PAT_OVERLOAD  = 3'd3;
    localparam logic [2:0] PAT_EMERGENCY = 3'd4;
    localparam logic [2:0] PAT_FAULT     = 3'd5;

    // register indexes
    localparam logic [1:0] REG_SHORT_BEEP = 2'd0;
    localparam logic [1:0] REG_LONG_BEEP  = 2'd1;
    localparam logic [1:0] REG_KEY_BEEP   = 2'd2;

    localparam logic [CFG_WIDTH-1:0] SHORT_BEEP_RESET = CFG_WIDTH'(100);
    localparam logic [CFG_WIDTH-1:0] LONG_BEEP_RESET  = CFG_WIDTH'(500);
    localparam logic [CFG_WIDTH-1:0] KEY_BEEP_RESET   = CFG_WIDTH'(40);

    localparam logic [EDGE_WIDTH-1:0] EDGES_ENDLESS  = 8'hFF;
    localparam logic [EDGE_WIDTH-1:0] EDGES_SINGLE   = EDGE_WIDTH'(1);
    localparam logic [EDGE_WIDTH-1:0] EDGES_OVERLOAD = EDGE_WIDTH'(3 * 2);

    localparam logic [TIMER_WIDTH-1:0] TIMER_MAX = '1;

    typedef struct packed {
        logic [CFG_WIDTH-1:0] short_beep_ticks;
        logic [CFG_WIDTH-1:0] long_beep_ticks;
        logic [CFG_WIDTH-1:0] key_beep_ticks;
    } bpg_cfg_t;

    typedef struct packed {
        logic       step;
        logic [1:0] mode;
        logic [2:0] pattern;
    } bpg_cmd_t;

    typedef struct packed {
        logic pin_level;
        logic busy_res;
    } bpg_status_t;

    // duration load, saturated to what the timer can hold
    function automatic logic [TIMER_WIDTH-1:0] timer_load(input logic [CFG_WIDTH-1:0] d);
        logic [TIMER_WIDTH-1:0] r;
        r = TIMER_WIDTH'(d);
        if (TIMER_WIDTH < CFG_WIDTH) begin
            if (d > CFG_WIDTH'(TIMER_MAX)) begin
                r = TIMER_MAX;
            end
        end
        return r;
    endfunction

endpackage

/* hw/rtl/bpg_engine.sv */
module bpg_engine (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  bpg_pkg::bpg_cfg_t     cfg,
    input  bpg_pkg::bpg_cmd_t     cmd,
    output bpg_pkg::bpg_status_t  status_next
);
    import bpg_pkg::*;

    logic [2:0]             pattern_reg, pattern_next;
    logic [TIMER_WIDTH-1:0] ticks_reg,   ticks_next;
    logic [EDGE_WIDTH-1:0]  edges_reg,   edges_next;
    logic                   pin_reg,     pin_next;
    logic [EDGE_WIDTH-1:0]  edges_dec;

    always_comb begin
        pattern_next = pattern_reg;
        ticks_next   = ticks_reg;
        edges_next   = edges_reg;
        pin_next     = pin_reg;
        edges_dec    = (edges_reg != '0) ? edges_reg - EDGE_WIDTH'(1) : '0;
        if (cmd.step) begin
            case (cmd.mode)
                MODE_TICK: begin
                    if (pattern_reg != PAT_NONE) begin
                        if (ticks_reg > TIMER_WIDTH'(1)) begin
                            ticks_next = ticks_reg - TIMER_WIDTH'(1);
                        end else begin
                            pin_next = ~pin_reg;
                            if (edges_reg != EDGES_ENDLESS && edges_dec == '0) begin
                                pattern_next = PAT_NONE;
                                ticks_next   = '0;
                                edges_next   = '0;
                                pin_next     = 1'b0;
                            end else begin
                                if (edges_reg != EDGES_ENDLESS) begin
                                    edges_next = edges_dec;
                                end
                                ticks_next = (pattern_reg == PAT_FAULT) ?
                                             timer_load(cfg.long_beep_ticks) :
                                             timer_load(cfg.short_beep_ticks);
                            end
                        end
                    end
                end
                MODE_TRIGGER: begin
                    pattern_next = cmd.pattern;
                    pin_next     = 1'b1;
                    case (cmd.pattern)
                        PAT_ARRIVAL: begin
                            edges_next = EDGES_SINGLE;
                            ticks_next = timer_load(cfg.short_beep_ticks);
                        end
                        PAT_KEY: begin
                            edges_next = EDGES_SINGLE;
                            ticks_next = timer_load(cfg.key_beep_ticks);
                        end
                        PAT_OVERLOAD: begin
                            edges_next = EDGES_OVERLOAD;
                            ticks_next = timer_load(cfg.short_beep_ticks);
                        end
                        PAT_EMERGENCY: begin
                            edges_next = EDGES_ENDLESS;
                            ticks_next = timer_load(cfg.short_beep_ticks);
                        end
                        PAT_FAULT: begin
                            edges_next = EDGES_ENDLESS;
                            ticks_next = timer_load(cfg.long_beep_ticks);
                        end
                        default: begin
                            // none or unknown pattern acts as stop
                            pattern_next = PAT_NONE;
                            ticks_next   = '0;
                            edges_next   = '0;
                            pin_next     = 1'b0;
                        end
                    endcase
                end
                MODE_STOP: begin
                    pattern_next = PAT_NONE;
                    ticks_next   = '0;
                    edges_next   = '0;
                    pin_next     = 1'b0;
                end
                default: begin
                end
            endcase
        end
    end

    assign status_next.pin_level = pin_next;
    assign status_next.busy_res  = (pattern_next != PAT_NONE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pattern_reg <= PAT_NONE;
            ticks_reg   <= '0;
            edges_reg   <= '0;
            pin_reg     <= 1'b0;
        end else begin
            pattern_reg <= pattern_next;
            ticks_reg   <= ticks_next;
            edges_reg   <= edges_next;
            pin_reg     <= pin_next;
        end
    end

endmodule

/* hw/rtl/buzzer_pattern_generator.sv */
// Buzzer beep pattern generator. Each input item is a millisecond tick, a trigger
// carrying a pattern, or a stop (kind in s_tuser); every accepted item returns one
// result item with the pin level and busy flag after that item. The block takes one
// item per clock while the output register can take it: the pattern state and
// that register load together when an item is accepted, so s_tready stays high
// while the register is empty or being drained. There is no clearing pass after
// reset. The user must write durations only while idle; the cfg port does not check.
module buzzer_pattern_generator (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [2:0] pattern, rest zero
    input  logic [1:0]  s_tuser,    // [1:0] mode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,    // [0] pin_level, [1] busy_res, rest zero
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_wdata
);
    import bpg_pkg::*;

    bpg_cfg_t    cfg_reg;
    bpg_cmd_t    cmd;
    bpg_status_t status_next;
    logic        m_valid_reg;
    bpg_status_t m_status_reg;
    logic        accept;

    assign s_tready = !m_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    assign cmd.step    = accept;
    assign cmd.mode    = s_tuser;
    assign cmd.pattern = s_tdata[2:0];

    bpg_engine u_engine (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg_reg),
        .cmd         (cmd),
        .status_next (status_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.short_beep_ticks <= SHORT_BEEP_RESET;
            cfg_reg.long_beep_ticks  <= LONG_BEEP_RESET;
            cfg_reg.key_beep_ticks   <= KEY_BEEP_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_SHORT_BEEP: cfg_reg.short_beep_ticks <= cfg_wdata;
                REG_LONG_BEEP:  cfg_reg.long_beep_ticks  <= cfg_wdata;
                REG_KEY_BEEP:   cfg_reg.key_beep_ticks   <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (accept) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            m_status_reg <= status_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {6'b0, m_status_reg.busy_res, m_status_reg.pin_level};

endmodule

/* hw/rtl/bpg_checker.sv */
module bpg_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic [7:0] s_tdata,
    input logic [1:0] s_tuser,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata
);
    import bpg_pkg::*;

    logic s_acc;
    logic trig_live;

    assign s_acc     = s_tvalid && s_tready;
    assign trig_live = (s_tdata[2:0] == PAT_ARRIVAL) || (s_tdata[2:0] == PAT_KEY) ||
                       (s_tdata[2:0] == PAT_OVERLOAD) || (s_tdata[2:0] == PAT_EMERGENCY) ||
                       (s_tdata[2:0] == PAT_FAULT);

    // an idle block never drives the pin
    a_idle_pin_off: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[1] |-> !m_tdata[0])
        else $error("pin on while not busy");

    a_stop_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_acc && s_tuser == MODE_STOP |=> m_tvalid && m_tdata[1:0] == 2'b00)
        else $error("stop item did not silence the block");

    a_trigger_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_acc && s_tuser == MODE_TRIGGER && trig_live |=> m_tvalid && m_tdata[1:0] == 2'b11)
        else $error("trigger item did not start a pattern");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

endmodule

bind buzzer_pattern_generator bpg_checker u_bpg_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

/* tb/testbench.sv */
`timescale 1ns / 100ps

import bpg_pkg::*;

// patterns outside the defined set, treated like none
localparam logic [2:0] PAT_UNKNOWN_LO = 3'd6;
localparam logic [2:0] PAT_UNKNOWN_HI = 3'd7;
localparam logic [1:0] MODE_UNUSED    = 2'd3;

class buzzer_scoreboard;
    logic [CFG_WIDTH-1:0]   short_ticks;
    logic [CFG_WIDTH-1:0]   long_ticks;
    logic [CFG_WIDTH-1:0]   key_ticks;
    logic [2:0]             cur_pat;
    logic [TIMER_WIDTH-1:0] ticks_left;
    logic [EDGE_WIDTH-1:0]  edges_left;
    logic                   pin;
    bpg_status_t            status_q[$];
    int                     errors;

    function new();
        short_ticks = SHORT_BEEP_RESET;
        long_ticks  = LONG_BEEP_RESET;
        key_ticks   = KEY_BEEP_RESET;
        errors      = 0;
        silence();
    endfunction

    function void write_reg(logic [1:0] idx, logic [CFG_WIDTH-1:0] val);
        case (idx)
            REG_SHORT_BEEP: short_ticks = val;
            REG_LONG_BEEP:  long_ticks  = val;
            REG_KEY_BEEP:   key_ticks   = val;
            default: ;
        endcase
    endfunction

    function logic [TIMER_WIDTH-1:0] clamp_dur(logic [CFG_WIDTH-1:0] d);
        if (64'(d) > 64'(TIMER_MAX)) return TIMER_MAX;
        return TIMER_WIDTH'(d);
    endfunction

    function void silence();
        pin        = 1'b0;
        cur_pat    = PAT_NONE;
        ticks_left = '0;
        edges_left = '0;
    endfunction

    function void start(logic [2:0] pat);
        cur_pat = pat;
        pin     = 1'b1;
        case (pat)
            PAT_ARRIVAL: begin
                edges_left = EDGES_SINGLE;
                ticks_left = clamp_dur(short_ticks);
            end
            PAT_KEY: begin
                edges_left = EDGES_SINGLE;
                ticks_left = clamp_dur(key_ticks);
            end
            PAT_OVERLOAD: begin
                edges_left = EDGES_OVERLOAD;
                ticks_left = clamp_dur(short_ticks);
            end
            PAT_EMERGENCY: begin
                edges_left = EDGES_ENDLESS;
                ticks_left = clamp_dur(short_ticks);
            end
            PAT_FAULT: begin
                edges_left = EDGES_ENDLESS;
                ticks_left = clamp_dur(long_ticks);
            end
            default: silence();
        endcase
    endfunction

    function void advance();
        if (cur_pat == PAT_NONE) return;
        if (ticks_left > 1) begin
            ticks_left = ticks_left - 1'b1;
            return;
        end
        pin = ~pin;
        if (edges_left != EDGES_ENDLESS) begin
            if (edges_left > 0) edges_left = edges_left - 1'b1;
            if (edges_left == 0) begin
                silence();
                return;
            end
        end
        ticks_left = clamp_dur(cur_pat == PAT_FAULT ? long_ticks : short_ticks);
    endfunction

    function void note_item(logic [1:0] mode, logic [2:0] pat);
        bpg_status_t st;
        case (mode)
            MODE_TICK:    advance();
            MODE_TRIGGER: start(pat);
            MODE_STOP:    silence();
            default: ;
        endcase
        st.pin_level = pin;
        st.busy_res  = (cur_pat != PAT_NONE);
        status_q.push_back(st);
    endfunction

    function void check_item(logic [7:0] data);
        bpg_status_t st;
        if (status_q.size() == 0) begin
            errors++;
            if (errors <= 10)
                $display("unexpected result item: pin=%0b busy=%0b", data[0], data[1]);
            return;
        end
        st = status_q.pop_front();
        if (data[0] !== st.pin_level || data[1] !== st.busy_res) begin
            errors++;
            if (errors <= 10)
                $display("status mismatch: expected pin=%0b busy=%0b, got pin=%0b busy=%0b",
                         st.pin_level, st.busy_res, data[0], data[1]);
        end
    endfunction

    function int pending();
        return status_q.size();
    endfunction
endclass

module testbench;
    localparam int STALL_LIMIT = 2000;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;
    logic [1:0]  s_tuser = MODE_TICK;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;
    logic        cfg_wr_en = 1'b0;
    logic [1:0]  cfg_index = REG_SHORT_BEEP;
    logic [15:0] cfg_wdata = '0;

    bit src_gaps = 1'b1;
    bit sink_stalls = 1'b1;
    int idle_cycles = 0;
    buzzer_scoreboard sb;

    buzzer_pattern_generator u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // result side with random backpressure bursts
    initial begin
        forever begin
            @(negedge aclk);
            if (sink_stalls && $urandom_range(0, 7) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(negedge aclk);
            end
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_item(m_tdata);
    end

    // ends the run if nothing moves on either side for too long
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles + 1 >= STALL_LIMIT) begin
                $display("Regression FAIL");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    task automatic send_item(input logic [1:0] mode, input logic [2:0] pat);
        int gap;
        gap = 0;
        if (src_gaps && $urandom_range(0, 5) == 0) gap = $urandom_range(1, 10);
        @(negedge aclk);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= {5'b0, pat};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_item(mode, pat);
    endtask

    task automatic drain();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (3) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        sb.write_reg(idx, val);
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic set_durations(input logic [15:0] s, input logic [15:0] l,
                                 input logic [15:0] k);
        drain();
        write_reg(REG_SHORT_BEEP, s);
        write_reg(REG_LONG_BEEP, l);
        write_reg(REG_KEY_BEEP, k);
    endtask

    function automatic logic [2:0] pick_pattern();
        if ($urandom_range(0, 7) == 0) begin
            case ($urandom_range(0, 3))
                0: return PAT_NONE;
                1: return PAT_UNKNOWN_LO;
                2: return PAT_UNKNOWN_HI;
                default: return PAT_ARRIVAL;
            endcase
        end
        case ($urandom_range(0, 4))
            0: return PAT_ARRIVAL;
            1: return PAT_KEY;
            2: return PAT_OVERLOAD;
            3: return PAT_EMERGENCY;
            default: return PAT_FAULT;
        endcase
    endfunction

    // enough ticks to run most patterns to the end at the current durations
    function automatic int tick_span();
        int m;
        m = int'(sb.short_ticks);
        if (int'(sb.long_ticks) > m) m = int'(sb.long_ticks);
        if (int'(sb.key_ticks) > m) m = int'(sb.key_ticks);
        m = m * 7 + 4;
        if (m > 48) m = 48;
        return m;
    endfunction

    // one trigger followed by a run of ticks with some noise mixed in
    task automatic run_burst(inout int count);
        int n;
        int r;
        send_item(MODE_TRIGGER, pick_pattern());
        count++;
        n = $urandom_range(0, tick_span());
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(0, 99);
            if (r < 90) begin
                send_item(MODE_TICK, 3'($urandom_range(0, 7)));
                count++;
            end else if (r < 94) begin
                send_item(MODE_STOP, 3'($urandom_range(0, 7)));
                count++;
            end else if (r < 97) begin
                send_item(MODE_UNUSED, 3'($urandom_range(0, 7)));
            end else begin
                send_item(MODE_TRIGGER, pick_pattern());
                count++;
            end
        end
    endtask

    task automatic run_phase(input logic [15:0] s, input logic [15:0] l,
                             input logic [15:0] k, input int target);
        int count;
        count = 0;
        set_durations(s, l, k);
        while (count < target) run_burst(count);
    endtask

    initial begin
        sb = new();
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // reset durations: idle tick, unused mode, unknown patterns, retrigger, stop
        send_item(MODE_TICK, PAT_UNKNOWN_HI);
        send_item(MODE_UNUSED, PAT_FAULT);
        send_item(MODE_TRIGGER, PAT_UNKNOWN_LO);
        send_item(MODE_TRIGGER, PAT_UNKNOWN_HI);
        send_item(MODE_TRIGGER, PAT_NONE);
        send_item(MODE_TRIGGER, PAT_ARRIVAL);
        send_item(MODE_TICK, PAT_NONE);
        send_item(MODE_TRIGGER, PAT_FAULT);
        send_item(MODE_TICK, PAT_NONE);
        send_item(MODE_STOP, PAT_NONE);

        // short durations so the finite patterns expire within a few ticks; endless ones are stopped
        set_durations(16'd1, 16'd2, 16'd1);
        send_item(MODE_TRIGGER, PAT_KEY);
        send_item(MODE_TICK, PAT_NONE);
        send_item(MODE_TRIGGER, PAT_ARRIVAL);
        send_item(MODE_TICK, PAT_NONE);
        send_item(MODE_TRIGGER, PAT_OVERLOAD);
        repeat (6) send_item(MODE_TICK, PAT_NONE);
        send_item(MODE_TRIGGER, PAT_EMERGENCY);
        send_item(MODE_TICK, PAT_NONE);
        send_item(MODE_TICK, PAT_NONE);
        send_item(MODE_TRIGGER, PAT_FAULT);
        send_item(MODE_TICK, PAT_NONE);
        send_item(MODE_TICK, PAT_NONE);
        send_item(MODE_TICK, PAT_NONE);
        send_item(MODE_STOP, PAT_NONE);

        run_phase(16'd1, 16'd1, 16'd1, 250);
        run_phase(16'd0, 16'd0, 16'd0, 200);
        run_phase(16'd3, 16'd5, 16'd2, 350);
        run_phase(16'hFFFF, 16'hFFFF, 16'hFFFF, 100);
        run_phase(16'($urandom_range(1, 8)), 16'($urandom_range(1, 8)),
                  16'($urandom_range(1, 8)), 200);
        run_phase(16'($urandom_range(1, 8)), 16'($urandom_range(1, 8)),
                  16'($urandom_range(1, 8)), 200);

        // last stretch runs at full rate on both sides
        drain();
        src_gaps    = 1'b0;
        sink_stalls = 1'b0;
        run_phase(16'd2, 16'd4, 16'd1, 350);

        drain();
        repeat (8) @(posedge aclk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end
endmodule
